// ===== rtl/ael_pkg.sv =====
// Package for the arithmetic expression lexer: widths, character codes,
// token kinds, lexer modes and the token record. No dependencies.
package ael_pkg;

    localparam int FRAC_BITS = 16;
    localparam int INT_BITS  = 31;
    localparam int FRAC_W    = FRAC_BITS + 1;       // fraction accumulator
    localparam int ACC_W     = INT_BITS + 4;        // int_acc * 10 + digit
    localparam int MAG_W     = INT_BITS + FRAC_BITS + 1;
    localparam int VALUE_W   = 49;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W     = $clog2(FIFO_DEPTH);
    localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);

    // round(2^FRAC_BITS / 10^k), k = 1..7
    localparam int STEP_1 = ((1 << FRAC_BITS) + 5) / 10;
    localparam int STEP_2 = ((1 << FRAC_BITS) + 50) / 100;
    localparam int STEP_3 = ((1 << FRAC_BITS) + 500) / 1000;
    localparam int STEP_4 = ((1 << FRAC_BITS) + 5000) / 10000;
    localparam int STEP_5 = ((1 << FRAC_BITS) + 50000) / 100000;
    localparam int STEP_6 = ((1 << FRAC_BITS) + 500000) / 1000000;
    localparam int STEP_7 = ((1 << FRAC_BITS) + 5000000) / 10000000;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        M_START    = 3'd0,
        M_INT      = 3'd1,
        M_FRAC     = 3'd2,
        M_AFTER_OP = 3'd3,
        M_IGNORE   = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        KIND_NUM = 2'd0,
        KIND_OP  = 2'd1,
        KIND_ERR = 2'd2
    } t_kind;

    // One queued token; number value is kept as sign/int/frac until output
    typedef struct packed {
        t_kind                 kind;
        logic [7:0]            op_code;
        logic                  neg;
        logic [INT_BITS-1:0]   int_part;
        logic [FRAC_W-1:0]     frac_part;
        logic                  expr_end;
        logic                  run_last;
    } t_tok;

    function automatic logic [FRAC_W-1:0] frac_step(input logic [2:0] k);
        logic [FRAC_W-1:0] s;
        unique case (k)
            3'd1:    s = FRAC_W'(STEP_1);
            3'd2:    s = FRAC_W'(STEP_2);
            3'd3:    s = FRAC_W'(STEP_3);
            3'd4:    s = FRAC_W'(STEP_4);
            3'd5:    s = FRAC_W'(STEP_5);
            3'd6:    s = FRAC_W'(STEP_6);
            3'd7:    s = FRAC_W'(STEP_7);
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic is_op_char(input logic [7:0] c);
        return (c == CH_SLASH) || (c == CH_STAR) || (c == CH_PLUS) ||
               (c == CH_MINUS) || (c == CH_LPAR) || (c == CH_RPAR);
    endfunction

    function automatic logic is_digit_char(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ===== rtl/arith_expr_lexer_top.sv =====
// Arithmetic expression lexer, top level: character decode, number
// accumulation, token queue and output register. Depends on ael_pkg.
//
//  channel  direction  handshake           payload
//  input    in         i_valid / o_ready   i_ch, i_is_final
//  output   out        o_valid / i_ready   o_kind, o_op_code, o_value,
//                                          o_expr_end, o_run_last
//
// Each character transaction is decoded and folded into the lexer state in
// the cycle it is accepted; its zero to two tokens go into a 4-entry queue.
// A token leaves the queue into the output register, where the signed
// fixed-point value is formed, one per cycle while i_ready is high. One
// character per cycle when each gives at most one token; the single output
// port sets the pace to one token per cycle. o_ready drops while fewer than
// two queue slots are free. Reset (synchronous, active low) returns to
// expression start and empties the queue and output register.
module arith_expr_lexer_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_ch,
    input  logic                        i_is_final,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_kind,
    output logic [7:0]                  o_op_code,
    output logic signed [ael_pkg::VALUE_W-1:0] o_value,
    output logic                        o_expr_end,
    output logic                        o_run_last
);
    import ael_pkg::*;

    // lexer state
    t_mode               r_mode, n_mode;
    logic                r_neg, n_neg;
    logic [INT_BITS-1:0] r_int, n_int;
    logic [FRAC_W-1:0]   r_frac, n_frac;
    logic [2:0]          r_fdig, n_fdig;

    // token queue
    t_tok                r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]    r_wr, r_rd;
    logic [CNT_W-1:0]    r_count, n_count;

    // output register
    logic                r_out_valid;
    t_kind               r_kind;
    logic [7:0]          r_op;
    logic signed [VALUE_W-1:0] r_value;
    logic                r_end, r_last;

    logic                acc, pop;
    logic                fin;
    logic [3:0]          digit;
    logic                want_old, want_op, want_new, want_err;
    logic [1:0]          tok_cnt;
    t_tok                tok_old, tok_op, tok_new, tok_err, slot0, slot1;
    logic [ACC_W-1:0]    int_mul;
    logic [FRAC_W+3:0]   frac_prod;
    logic [MAG_W-1:0]    mag;
    logic signed [VALUE_W-1:0] val;
    t_tok                head;

    assign acc   = i_valid && o_ready;
    assign fin   = i_is_final;
    assign digit = 4'(i_ch - CH_ZERO);
    assign o_ready = (r_count <= CNT_W'(FIFO_DEPTH - 2));

    // int_acc * 10 + digit, then saturate
    assign int_mul = (ACC_W'(r_int) << 3) + (ACC_W'(r_int) << 1) + ACC_W'(digit);
    assign frac_prod = (FRAC_W+4)'(digit) * (FRAC_W+4)'(frac_step(r_fdig + 3'd1));

    // next lexer state and which tokens this character raises
    always_comb begin
        n_mode   = r_mode;
        n_neg    = r_neg;
        n_int    = r_int;
        n_frac   = r_frac;
        n_fdig   = r_fdig;
        want_old = 1'b0;
        want_op  = 1'b0;
        want_new = 1'b0;
        want_err = 1'b0;
        unique case (r_mode)
            M_START: begin
                if (i_ch == CH_PLUS || i_ch == CH_MINUS) begin
                    n_neg = (i_ch == CH_MINUS);
                    n_int = '0; n_frac = '0; n_fdig = '0;
                    n_mode = M_INT;
                    want_new = fin;
                end else if (is_digit_char(i_ch)) begin
                    n_neg = 1'b0; n_frac = '0; n_fdig = '0;
                    n_int = INT_BITS'(digit);
                    n_mode = M_INT;
                    want_new = fin;
                end else if (i_ch == CH_DOT) begin
                    n_neg = 1'b0; n_int = '0; n_frac = '0; n_fdig = '0;
                    n_mode = M_FRAC;
                    want_new = fin;
                end else if (i_ch == CH_LPAR) begin
                    want_op = 1'b1;
                    n_mode = M_AFTER_OP;
                end else begin
                    want_err = 1'b1;
                end
            end
            M_INT: begin
                if (is_digit_char(i_ch)) begin
                    n_int = (int_mul > ACC_W'({INT_BITS{1'b1}})) ?
                            {INT_BITS{1'b1}} : INT_BITS'(int_mul);
                    want_new = fin;
                end else if (i_ch == CH_DOT) begin
                    n_mode = M_FRAC;
                    want_new = fin;
                end else if (is_op_char(i_ch)) begin
                    want_old = 1'b1;
                    want_op  = 1'b1;
                    n_mode = M_AFTER_OP;
                end else begin
                    want_err = 1'b1;
                end
            end
            M_FRAC: begin
                if (is_digit_char(i_ch)) begin
                    if (r_fdig != 3'd7) begin
                        n_fdig = r_fdig + 3'd1;
                        n_frac = r_frac + FRAC_W'(frac_prod);
                    end
                    want_new = fin;
                end else if (i_ch == CH_DOT) begin
                    // second dot: close this number, open a fraction-only one
                    want_old = 1'b1;
                    n_neg = 1'b0; n_int = '0; n_frac = '0; n_fdig = '0;
                    want_new = fin;
                end else if (is_op_char(i_ch)) begin
                    want_old = 1'b1;
                    want_op  = 1'b1;
                    n_mode = M_AFTER_OP;
                end else begin
                    want_err = 1'b1;
                end
            end
            M_AFTER_OP: begin
                if (is_digit_char(i_ch)) begin
                    n_neg = 1'b0; n_frac = '0; n_fdig = '0;
                    n_int = INT_BITS'(digit);
                    n_mode = M_INT;
                    want_new = fin;
                end else if (i_ch == CH_DOT) begin
                    n_neg = 1'b0; n_int = '0; n_frac = '0; n_fdig = '0;
                    n_mode = M_FRAC;
                    want_new = fin;
                end else if (is_op_char(i_ch)) begin
                    want_op = 1'b1;
                end else begin
                    want_err = 1'b1;
                end
            end
            M_IGNORE: begin
            end
            default: begin
            end
        endcase
        if (want_err) begin
            n_neg = 1'b0; n_int = '0; n_frac = '0; n_fdig = '0;
            n_mode = M_IGNORE;
        end
    end

    // token records, in emission order: old number, operator, new number, error
    always_comb begin
        tok_old = '{kind: KIND_NUM, op_code: 8'd0, neg: r_neg, int_part: r_int,
                    frac_part: r_frac, expr_end: 1'b0, run_last: 1'b0};
        tok_op  = '{kind: KIND_OP, op_code: i_ch, neg: 1'b0, int_part: '0,
                    frac_part: '0, expr_end: fin, run_last: 1'b0};
        tok_new = '{kind: KIND_NUM, op_code: 8'd0, neg: n_neg, int_part: n_int,
                    frac_part: n_frac, expr_end: 1'b1, run_last: 1'b0};
        tok_err = '{kind: KIND_ERR, op_code: 8'd0, neg: 1'b0, int_part: '0,
                    frac_part: '0, expr_end: 1'b1, run_last: 1'b0};
        tok_cnt = 2'(want_old) + 2'(want_op) + 2'(want_new) + 2'(want_err);
        if (want_old) begin
            slot0 = tok_old;
        end else if (want_op) begin
            slot0 = tok_op;
        end else if (want_new) begin
            slot0 = tok_new;
        end else begin
            slot0 = tok_err;
        end
        slot1 = want_op ? tok_op : tok_new;
        slot0.run_last = (tok_cnt == 2'd1);
        slot1.run_last = 1'b1;
    end

    // lexer state registers; the final character returns to expression start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_START;
            r_neg  <= 1'b0;
            r_int  <= '0;
            r_frac <= '0;
            r_fdig <= '0;
        end else if (acc) begin
            if (fin) begin
                r_mode <= M_START;
                r_neg  <= 1'b0;
                r_int  <= '0;
                r_frac <= '0;
                r_fdig <= '0;
            end else begin
                r_mode <= n_mode;
                r_neg  <= n_neg;
                r_int  <= n_int;
                r_frac <= n_frac;
                r_fdig <= n_fdig;
            end
        end
    end

    // queue: up to two writes and one read per cycle
    assign pop     = (r_count != '0) && (!r_out_valid || i_ready);
    assign n_count = r_count + (acc ? CNT_W'(tok_cnt) : '0) - CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (acc) begin
                r_wr <= r_wr + PTR_W'(tok_cnt);
            end
            if (pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && tok_cnt != 2'd0) begin
            r_fifo[r_wr] <= slot0;
        end
        if (acc && tok_cnt == 2'd2) begin
            r_fifo[r_wr + PTR_W'(1)] <= slot1;
        end
    end

    // value = +/- (int << FRAC_BITS) + frac; op and error tokens carry zeros
    assign head = r_fifo[r_rd];
    assign mag  = (MAG_W'(head.int_part) << FRAC_BITS) + MAG_W'(head.frac_part);
    assign val  = head.neg ? -VALUE_W'(mag) : VALUE_W'(mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_kind  <= head.kind;
            r_op    <= head.op_code;
            r_value <= val;
            r_end   <= head.expr_end;
            r_last  <= head.run_last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_kind     = r_kind;
    assign o_op_code  = r_op;
    assign o_value    = r_value;
    assign o_expr_end = r_end;
    assign o_run_last = r_last;

endmodule

// ===== dv/arith_expr_lexer_checker.sv =====
// Token checker for the arithmetic expression lexer: watches both channels,
// predicts the tokens of each accepted character and compares them in order.
// Depends on ael_pkg.
`timescale 1ns / 1ps

module arith_expr_lexer_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [7:0]                        i_ch,
    input  logic                              i_is_final,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [1:0]                        i_kind,
    input  logic [7:0]                        i_op_code,
    input  logic signed [ael_pkg::VALUE_W-1:0] i_value,
    input  logic                              i_expr_end,
    input  logic                              i_run_last,
    output int                                o_err_count,
    output int                                o_pending
);
    import ael_pkg::*;

    localparam logic [ACC_W-1:0] INT_CEIL = (ACC_W'(1) << INT_BITS) - 1;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         op_code;
        logic [VALUE_W-1:0] value;
        logic               expr_end;
        logic               run_last;
    } t_lex_token;

    t_lex_token expected_tokens[$];
    int         bad_tokens = 0;

    // lexer state as predicted
    t_mode               lx_mode;
    logic                lx_neg;
    logic [INT_BITS-1:0] lx_int;
    logic [FRAC_W-1:0]   lx_frac;
    logic [2:0]          lx_fdig;

    function automatic logic [FRAC_W-1:0] frac_weight(input int k);
        longint p;
        p = 1;
        for (int i = 0; i < k; i++) p = p * 10;
        return FRAC_W'(((longint'(1) << FRAC_BITS) + p / 2) / p);
    endfunction

    function automatic void clear_number();
        lx_neg  = 1'b0;
        lx_int  = '0;
        lx_frac = '0;
        lx_fdig = '0;
    endfunction

    function automatic void push_token(input t_kind kind, input logic [7:0] op,
                                       input logic [VALUE_W-1:0] value,
                                       input logic last_of_expr);
        t_lex_token t;
        t.kind     = kind;
        t.op_code  = op;
        t.value    = value;
        t.expr_end = last_of_expr;
        t.run_last = 1'b0;
        expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    function automatic void push_number(input logic last_of_expr);
        logic [VALUE_W-1:0] mag;
        mag = (VALUE_W'(lx_int) << FRAC_BITS) + VALUE_W'(lx_frac);
        push_token(KIND_NUM, 8'h00, lx_neg ? -mag : mag, last_of_expr);
    endfunction

    // fold one character into the state, queue the tokens it produces
    function automatic void lex_char(input logic [7:0] c, input logic fin);
        int         first;
        logic       err;
        logic       is_dig;
        logic       is_op;
        logic [3:0] dv;
        logic [ACC_W-1:0] grown;
        t_lex_token tail;
        first  = expected_tokens.size();
        err    = 1'b0;
        is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
        is_op  = (c == CH_SLASH) || (c == CH_STAR) || (c == CH_PLUS) ||
                 (c == CH_MINUS) || (c == CH_LPAR) || (c == CH_RPAR);
        dv     = 4'(c - CH_ZERO);
        case (lx_mode)
            M_START: begin
                if (c == CH_PLUS || c == CH_MINUS) begin
                    clear_number();
                    lx_neg  = (c == CH_MINUS);
                    lx_mode = M_INT;
                    if (fin) push_number(1'b1);
                end else if (is_dig) begin
                    clear_number();
                    lx_int  = INT_BITS'(dv);
                    lx_mode = M_INT;
                    if (fin) push_number(1'b1);
                end else if (c == CH_DOT) begin
                    clear_number();
                    lx_mode = M_FRAC;
                    if (fin) push_number(1'b1);
                end else if (c == CH_LPAR) begin
                    push_token(KIND_OP, c, '0, fin);
                    lx_mode = M_AFTER_OP;
                end else begin
                    err = 1'b1;
                end
            end
            M_INT: begin
                if (is_dig) begin
                    grown  = ACC_W'(lx_int) * ACC_W'(10) + ACC_W'(dv);
                    lx_int = (grown > INT_CEIL) ? INT_CEIL[INT_BITS-1:0]
                                                : grown[INT_BITS-1:0];
                    if (fin) push_number(1'b1);
                end else if (c == CH_DOT) begin
                    lx_mode = M_FRAC;
                    if (fin) push_number(1'b1);
                end else if (is_op) begin
                    push_number(1'b0);
                    push_token(KIND_OP, c, '0, fin);
                    lx_mode = M_AFTER_OP;
                end else begin
                    err = 1'b1;
                end
            end
            M_FRAC: begin
                if (is_dig) begin
                    // digits past the seventh add nothing
                    if (lx_fdig < 3'd7) begin
                        lx_fdig = lx_fdig + 3'd1;
                        lx_frac = lx_frac + FRAC_W'(dv) * frac_weight(int'(lx_fdig));
                    end
                    if (fin) push_number(1'b1);
                end else if (c == CH_DOT) begin
                    // second dot: close this number, open a fraction-only one
                    push_number(1'b0);
                    clear_number();
                    if (fin) push_number(1'b1);
                end else if (is_op) begin
                    push_number(1'b0);
                    push_token(KIND_OP, c, '0, fin);
                    lx_mode = M_AFTER_OP;
                end else begin
                    err = 1'b1;
                end
            end
            M_AFTER_OP: begin
                if (is_dig) begin
                    clear_number();
                    lx_int  = INT_BITS'(dv);
                    lx_mode = M_INT;
                    if (fin) push_number(1'b1);
                end else if (c == CH_DOT) begin
                    clear_number();
                    lx_mode = M_FRAC;
                    if (fin) push_number(1'b1);
                end else if (is_op) begin
                    push_token(KIND_OP, c, '0, fin);
                end else begin
                    err = 1'b1;
                end
            end
            default: ;
        endcase
        if (err) begin
            push_token(KIND_ERR, 8'h00, '0, 1'b1);
            clear_number();
            lx_mode = M_IGNORE;
        end
        if (fin) begin
            clear_number();
            lx_mode = M_START;
        end
        if (expected_tokens.size() > first) begin
            tail = expected_tokens[expected_tokens.size() - 1];
            tail.run_last = 1'b1;
            expected_tokens[expected_tokens.size() - 1] = tail;
        end
    endfunction

    function automatic void check_token();
        t_lex_token want;
        if (expected_tokens.size() == 0) begin
            bad_tokens++;
            if (bad_tokens <= 10)
                $display("%0t: unexpected token kind=%0d op=%02h value=%0d end=%b last=%b",
                         $realtime, i_kind, i_op_code, i_value, i_expr_end, i_run_last);
        end else begin
            want = expected_tokens.pop_front();
            if (i_kind !== want.kind || i_op_code !== want.op_code ||
                i_value !== want.value || i_expr_end !== want.expr_end ||
                i_run_last !== want.run_last) begin
                bad_tokens++;
                if (bad_tokens <= 10) begin
                    $display("%0t: token mismatch exp kind=%0d op=%02h value=%0d end=%b last=%b",
                             $realtime, want.kind, want.op_code, $signed(want.value),
                             want.expr_end, want.run_last);
                    $display("    got kind=%0d op=%02h value=%0d end=%b last=%b",
                             i_kind, i_op_code, i_value, i_expr_end, i_run_last);
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_tokens.delete();
            clear_number();
            lx_mode = M_START;
        end else begin
            if (i_in_valid && i_in_ready) lex_char(i_ch, i_is_final);
            if (i_out_valid && i_out_ready) check_token();
        end
        o_pending   <= expected_tokens.size();
        o_err_count <= bad_tokens;
    end

endmodule

// ===== dv/arith_expr_lexer_top_tb.sv =====
// Testbench top for the arithmetic expression lexer: clock, reset, character
// stimulus, token-side back-pressure and the verdict. Depends on ael_pkg,
// arith_expr_lexer_top and arith_expr_lexer_checker.
`timescale 1ns / 1ps

module arith_expr_lexer_top_tb;
    import ael_pkg::*;

    localparam int N_ITEMS      = 750;     // random characters to send
    localparam int QUIET_TAIL   = 80;      // last characters sent with no idling
    localparam int HOLD_CYCLES  = 80;      // long token-side stall, fills the queue
    localparam int DRAIN_CYCLES = 20;
    localparam int LIMIT_CYCLES = 200000;

    logic clk = 1'b0;
    logic rst_n;

    // character channel
    logic       ch_valid;
    logic       ch_ready;
    logic [7:0] ch_byte;
    logic       ch_final;

    // token channel
    logic                      tok_valid;
    logic                      tok_ready;
    logic [1:0]                tok_kind;
    logic [7:0]                tok_op;
    logic signed [VALUE_W-1:0] tok_value;
    logic                      tok_expr_end;
    logic                      tok_run_last;

    int err_count;
    int pending;

    // chars_sent and idle_level are shared between the sender and the receiver process
    int chars_sent;     // random characters accepted, ignored tail excluded
    int idle_level;     // 0 none, 1 light, 2 heavy
    bit hold_done;
    int cycle_count = 0;

    // current random expression
    logic [7:0] expr_bytes[$];
    int         noise_at;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    arith_expr_lexer_top u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (ch_valid),
        .o_ready    (ch_ready),
        .i_ch       (ch_byte),
        .i_is_final (ch_final),
        .o_valid    (tok_valid),
        .i_ready    (tok_ready),
        .o_kind     (tok_kind),
        .o_op_code  (tok_op),
        .o_value    (tok_value),
        .o_expr_end (tok_expr_end),
        .o_run_last (tok_run_last)
    );

    arith_expr_lexer_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (ch_valid),
        .i_in_ready  (ch_ready),
        .i_ch        (ch_byte),
        .i_is_final  (ch_final),
        .i_out_valid (tok_valid),
        .i_out_ready (tok_ready),
        .i_kind      (tok_kind),
        .i_op_code   (tok_op),
        .i_value     (tok_value),
        .i_expr_end  (tok_expr_end),
        .i_run_last  (tok_run_last),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    // Offer one character and wait for its transaction. An optional idle
    // burst comes first; valid is only dropped when a burst is taken, so a
    // back-to-back character keeps valid high without a glitch.
    task automatic send_char(input logic [7:0] c, input logic fin);
        if (idle_level != 0 && $urandom_range(0, 9) < 2 * idle_level) begin
            ch_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        ch_valid <= 1'b1;
        ch_byte  <= c;
        ch_final <= fin;
        // o_ready is read right after the edge, i.e. its pre-edge value
        do @(posedge clk); while (!ch_ready);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    function automatic void add_byte(input logic [7:0] b);
        expr_bytes.insert(expr_bytes.size(), b);
    endfunction

    function automatic void push_digits(input int count);
        for (int i = 0; i < count; i++)
            add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    // One number: mostly short, sometimes long enough to saturate the integer
    // part or to run past seven fraction digits, sometimes a second dot.
    function automatic void push_number();
        int  style;
        int  n_int;
        bit  has_frac;
        style    = $urandom_range(0, 19);
        n_int    = (style == 0) ? $urandom_range(9, 12) : $urandom_range(0, 3);
        has_frac = (style == 1) || ($urandom_range(0, 2) == 0);
        if (n_int == 0 && !has_frac) n_int = 1;
        push_digits(n_int);
        if (has_frac) begin
            add_byte(CH_DOT);
            push_digits((style == 1) ? $urandom_range(8, 10) : $urandom_range(0, 4));
            if ($urandom_range(0, 9) == 0) begin
                add_byte(CH_DOT);
                push_digits($urandom_range(0, 2));
            end
        end
    endfunction

    // Build the next random expression into expr_bytes. Most are well formed
    // with random content; a few are pure noise or get one byte replaced.
    function automatic void build_expr();
        logic [7:0] ops[4];
        int         n_terms;
        int         depth;
        ops      = '{CH_SLASH, CH_STAR, CH_PLUS, CH_MINUS};
        depth    = 0;
        noise_at = -1;
        expr_bytes.delete();
        if ($urandom_range(0, 99) < 6) begin
            repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
            noise_at = 0;
        end else begin
            if ($urandom_range(0, 3) == 0)
                add_byte($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            n_terms = $urandom_range(1, 4);
            for (int t = 0; t < n_terms; t++) begin
                if ($urandom_range(0, 4) == 0) begin
                    add_byte(CH_LPAR);
                    depth++;
                end
                push_number();
                if (depth > 0 && $urandom_range(0, 1) == 1) begin
                    add_byte(CH_RPAR);
                    depth--;
                end
                if (t != n_terms - 1) begin
                    add_byte(ops[$urandom_range(0, 3)]);
                    // sign after an operator is just another operator
                    if ($urandom_range(0, 7) == 0)
                        add_byte(ops[$urandom_range(2, 3)]);
                end
            end
            while (depth > 0) begin
                add_byte(CH_RPAR);
                depth--;
            end
            if ($urandom_range(0, 9) == 0) begin
                noise_at = $urandom_range(0, expr_bytes.size() - 1);
                expr_bytes[noise_at] = 8'($urandom_range(0, 255));
            end
        end
    endfunction

    // Sender: reset, directed expressions, random expressions, then wait for
    // the token stream to drain and give the verdict.
    initial begin
        rst_n      <= 1'b0;
        ch_valid   <= 1'b0;
        ch_byte    <= 8'h00;
        ch_final   <= 1'b0;
        chars_sent  = 0;
        idle_level  = 1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sign alone and lone dot, each as a whole expression -> number 0
        send_text("-");
        send_text(".");
        // second dot, final on the dot -> two numbers from one character
        send_text("1.5.");
        // open paren at start, sign after an operator, every operator
        send_text("(-/*+)");
        // bad first character with the byte extremes; the rest is ignored
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        // leading plus, fraction running past seven digits
        send_text("+.12345678");
        // invalid byte inside a number drops the number
        send_text("4x5");

        while (chars_sent < N_ITEMS) begin
            build_expr();
            for (int i = 0; i < expr_bytes.size(); i++) begin
                if (chars_sent >= N_ITEMS - QUIET_TAIL)
                    idle_level = 0;
                else
                    idle_level = ((chars_sent / 100) + 1) % 3;
                send_char(expr_bytes[i], i == expr_bytes.size() - 1);
                if (noise_at < 0 || i <= noise_at) chars_sent++;
            end
        end
        ch_valid <= 1'b0;

        // one more edge so the pending count covers the last character
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random ready bursts, one long stall once the run is under way
    // so the token queue fills and the character side backs up.
    initial begin
        tok_ready <= 1'b0;
        hold_done  = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (!hold_done && chars_sent >= 250) begin
                hold_done = 1'b1;
                tok_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (idle_level != 0 && $urandom_range(0, 5) < idle_level) begin
                tok_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end else begin
                tok_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

// ===== files.f =====
rtl/ael_pkg.sv
rtl/arith_expr_lexer_top.sv
dv/arith_expr_lexer_checker.sv
dv/arith_expr_lexer_top_tb.sv
